FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: rtl/cgs_pkg.sv
// ----------------------------------------------------------------------------
// cgs_pkg
// Types, constants and glyph tables of the contextual glyph shaper.
// ----------------------------------------------------------------------------
`default_nettype none

package cgs_pkg;

    localparam int NAME_CAPACITY = 8;
    localparam int CNT_W = $clog2(NAME_CAPACITY + 1);
    localparam int IDX_W = (NAME_CAPACITY > 1) ? $clog2(NAME_CAPACITY) : 1;
    localparam int TOK_D = NAME_CAPACITY + 1;

    localparam logic [5:0] LETTER_COUNT   = 6'd33;
    localparam logic [5:0] LITERAL_END    = 6'd50;
    localparam logic [7:0] LIGATURE_ALONE = 8'hF4;
    localparam logic [7:0] LIGATURE_JOIN  = 8'hF5;
    localparam logic [7:0] END_MARK       = 8'h3E;
    localparam logic [7:0] GLYPH_BASE     = 8'h80;
    localparam logic [7:0] SPACE_BYTE     = 8'h20;

    localparam int KIND_DUAL = 0;
    localparam int KIND_LAM  = 1;
    localparam int KIND_ALEF = 2;

    localparam logic [7:0] FORM_BASE [33] = '{
        8'h00, 8'h02, 8'h06, 8'h0A, 8'h0E, 8'h12, 8'h16, 8'h1A, 8'h1E, 8'h22, 8'h24,
        8'h26, 8'h28, 8'h2A, 8'h2C, 8'h30, 8'h34, 8'h38, 8'h3C, 8'h40, 8'h44, 8'h48,
        8'h4C, 8'h50, 8'h54, 8'h58, 8'h5C, 8'h60, 8'h64, 8'h68, 8'h6A, 8'h6E, 8'h72
    };

    localparam logic [2:0] LETTER_KIND [33] = '{
        3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd1, 3'd1, 3'd0, 3'd1, 3'd1, 3'd4
    };

    // Offset of a dual-joining form, indexed by {prev_connects, next_connects}.
    localparam logic [1:0] DUAL_OFFSET [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

    localparam logic [7:0] LITERAL_BYTE [17] = '{
        8'h20, 8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD,
        8'hFE, 8'hFF, 8'h2E, 8'h28, 8'h29, 8'h2C, 8'h60, 8'h5F
    };

    typedef struct packed {
        logic [5:0] token;
        logic       last_token;
    } t_in_item;

    typedef struct packed {
        logic [7:0] glyph_byte;
        logic [3:0] glyph_count;
        logic       is_terminator;
        logic       overflowed;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHAPE,
        ST_EMIT,
        ST_TERM
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
        logic term;
    } t_cmd;

    typedef struct packed {
        logic rem_zero;
        logic rd_zero;
        logic rd_one;
    } t_status;

    function automatic logic [2:0] kind_of(input logic [5:0] t);
        logic [2:0] k;
        k = 3'd0;
        if (t < LETTER_COUNT) begin
            k = LETTER_KIND[t];
        end
        return k;
    endfunction

    function automatic logic [7:0] literal_of(input logic [5:0] t);
        logic [7:0] b;
        b = SPACE_BYTE;
        if (t >= LETTER_COUNT && t < LITERAL_END) begin
            b = LITERAL_BYTE[5'(t - LETTER_COUNT)];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rtl_contextual_glyph_shaper.sv
// ----------------------------------------------------------------------------
// rtl_contextual_glyph_shaper
// Buffers the tokens of a name, shapes letters into contextual glyphs with
// lam-alef ligatures, and emits the bytes right to left plus a terminator.
//
//   channel   handshake              payload
//   item in   start & !busy          i_item   (t_in_item)
//   result    o_strobe, one cycle    o_result (t_result)
//
// A token not marked last leaves busy low.
// A last token of a name keeps busy high while the name is shaped, one
// shaping step per cycle through the token shift line, then while the bytes
// are emitted, one byte per cycle from the shaped stack, and for the terminator.
// Results appear in the cycle after their emit cycle and cannot be held off.
// Reset is synchronous, active low, and empties the name buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module rtl_contextual_glyph_shaper
    import cgs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_in_item i_item,
    output logic          busy,
    output logic          o_strobe,
    output t_result       o_result
);

    t_cmd    w_cmd;
    t_status w_status;

    cgs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_item.last_token),
        .i_status (w_status),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    cgs_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

FILE: rtl/cgs_ctrl.sv
// ----------------------------------------------------------------------------
// cgs_ctrl
// Sequencer: collect tokens, shape the name, emit bytes, emit terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module cgs_ctrl
    import cgs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_last,
    input  wire t_status i_status,
    output logic         o_busy,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_last) begin
                    n_state = ST_SHAPE;
                end
            end
            ST_SHAPE: begin
                if (i_status.rem_zero) begin
                    n_state = i_status.rd_zero ? ST_TERM : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.rd_one) begin
                    n_state = ST_TERM;
                end
            end
            ST_TERM: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy = 1'b1;
        o_cmd  = '0;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_SHAPE: begin
                o_cmd.step = !i_status.rem_zero;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
            end
            ST_TERM: begin
                o_cmd.term = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/cgs_datapath.sv
// ----------------------------------------------------------------------------
// cgs_datapath
// Token shift line, shaping step, shaped byte stack and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cgs_datapath
    import cgs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_item,
    input  wire t_cmd     i_cmd,
    output t_status       o_status,
    output logic          o_strobe,
    output t_result       o_result
);

    logic [5:0]       r_tok [TOK_D];
    logic [5:0]       n_tok [TOK_D];
    logic [7:0]       r_shaped [NAME_CAPACITY];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_m, n_m;
    logic [CNT_W-1:0] r_rd, n_rd;
    logic             r_prev, n_prev;
    logic             r_strobe;
    t_result          r_result;

    logic [5:0]       w_ext [TOK_D+2];
    logic [5:0]       w_t0, w_t1;
    logic [2:0]       w_k0, w_k1;
    logic             w_nxt_letter, w_next_conn, w_lig;
    logic             w_two;
    logic             w_keep;
    logic [CNT_W-1:0] w_cnt_inc;
    logic [7:0]       w_byte;
    logic             w_prev_out;

    assign w_t0 = r_tok[0];
    assign w_t1 = r_tok[1];
    assign w_k0 = kind_of(w_t0);
    assign w_k1 = kind_of(w_t1);

    // Lookahead stops at the last buffered token.
    assign w_nxt_letter = (r_rem > CNT_W'(1)) && (w_t1 < LETTER_COUNT);
    assign w_next_conn  = w_k0[KIND_DUAL] && w_nxt_letter;
    assign w_lig        = w_k0[KIND_LAM] && w_nxt_letter && w_k1[KIND_ALEF];

    always_comb begin
        w_two      = 1'b0;
        w_prev_out = 1'b0;
        if (w_t0 >= LETTER_COUNT) begin
            w_byte = literal_of(w_t0);
        end else if (w_lig) begin
            w_byte = r_prev ? LIGATURE_JOIN : LIGATURE_ALONE;
            w_two  = 1'b1;
        end else if (w_k0[KIND_DUAL]) begin
            w_byte     = GLYPH_BASE + FORM_BASE[w_t0]
                       + {6'd0, DUAL_OFFSET[{r_prev, w_next_conn}]};
            w_prev_out = 1'b1;
        end else begin
            w_byte = GLYPH_BASE + FORM_BASE[w_t0] + {7'd0, r_prev};
        end
    end

    assign w_keep    = r_cnt < CNT_W'(NAME_CAPACITY);
    assign w_cnt_inc = w_keep ? r_cnt + CNT_W'(1) : r_cnt;

    always_comb begin
        for (int j = 0; j < TOK_D; j++) begin
            w_ext[j] = r_tok[j];
        end
        w_ext[TOK_D]   = 6'd0;
        w_ext[TOK_D+1] = 6'd0;
    end

    always_comb begin
        n_tok  = r_tok;
        n_cnt  = r_cnt;
        n_ovf  = r_ovf;
        n_rem  = r_rem;
        n_m    = r_m;
        n_rd   = r_rd;
        n_prev = r_prev;
        if (i_cmd.load) begin
            if (w_keep) begin
                n_tok[IDX_W'(r_cnt)] = i_item.token;
            end else begin
                n_ovf = 1'b1;
            end
            n_cnt = w_cnt_inc;
            if (i_item.last_token) begin
                n_rem  = w_cnt_inc;
                n_m    = '0;
                n_rd   = '0;
                n_prev = 1'b0;
            end
        end
        if (i_cmd.step) begin
            // advance the token line by one token, or two for a ligature
            for (int j = 0; j < TOK_D; j++) begin
                n_tok[j] = w_two ? w_ext[j+2] : w_ext[j+1];
            end
            n_rem  = r_rem - (w_two ? CNT_W'(2) : CNT_W'(1));
            n_m    = r_m + CNT_W'(1);
            n_rd   = r_m + CNT_W'(1);
            n_prev = w_prev_out;
        end
        if (i_cmd.emit) begin
            n_rd = r_rd - CNT_W'(1);
        end
        if (i_cmd.term) begin
            n_cnt = '0;
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_rem    <= '0;
            r_m      <= '0;
            r_rd     <= '0;
            r_prev   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_rem    <= n_rem;
            r_m      <= n_m;
            r_rd     <= n_rd;
            r_prev   <= n_prev;
            r_strobe <= i_cmd.emit || i_cmd.term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (i_cmd.step) begin
            r_shaped[IDX_W'(r_m)] <= w_byte;
        end
        if (i_cmd.emit || i_cmd.term) begin
            r_result.glyph_count   <= 4'(r_m);
            r_result.overflowed    <= r_ovf;
            r_result.is_terminator <= i_cmd.term;
            r_result.glyph_byte    <= i_cmd.term ? END_MARK
                                                 : r_shaped[IDX_W'(r_rd - CNT_W'(1))];
        end
    end

    assign o_status.rem_zero = (r_rem == '0);
    assign o_status.rd_zero  = (r_rd == '0);
    assign o_status.rd_one   = (r_rd == CNT_W'(1));
    assign o_strobe          = r_strobe;
    assign o_result          = r_result;

endmodule

`default_nettype wire

FILE: rtl/cgs_checker.sv
// ----------------------------------------------------------------------------
// cgs_checker
// Port-level checks of the glyph shaper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cgs_checker
    import cgs_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     start,
    input wire t_in_item i_item,
    input wire logic     busy,
    input wire logic     o_strobe,
    input wire t_result  o_result
);

    `ASSERT_NXT(a_mid_token_idle, start && !busy && !i_item.last_token, !busy)
    `ASSERT_NXT(a_last_goes_busy, start && !busy && i_item.last_token, busy)
    `ASSERT_NXT(a_term_ends_run, o_strobe && o_result.is_terminator, !o_strobe)
    `ASSERT_IMP(a_byte_has_count, o_strobe && !o_result.is_terminator, o_result.glyph_count != 4'd0)

endmodule

bind rtl_contextual_glyph_shaper cgs_checker u_cgs_checker (.*);

`default_nettype wire
